/* design/fairrw_pkg.sv */
// ----------------------------------------------------------------------------
// fairrw_pkg
// Types, codes and helpers shared by the fair shared/exclusive gate.
// ----------------------------------------------------------------------------
package fairrw_pkg;

    // Request codes
    localparam logic [1:0] OP_ENTER_SHARED = 2'd0;
    localparam logic [1:0] OP_ENTER_EXCL   = 2'd1;
    localparam logic [1:0] OP_EXIT         = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_GRANTED  = 3'd0;
    localparam logic [2:0] KIND_QUEUED   = 3'd1;
    localparam logic [2:0] KIND_RELEASED = 3'd2;
    localparam logic [2:0] KIND_WOKEN    = 3'd3;
    localparam logic [2:0] KIND_EXIT_ERR = 3'd4;
    localparam logic [2:0] KIND_FULL     = 3'd5;

    localparam logic [6:0] HOLD_SAT        = 7'd64;
    localparam logic [6:0] MAX_EXCL_RESET  = 7'd1;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] requester_id;
    } req_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] requester_id_res;
        logic       shared_mode;
        logic       last;
        logic [4:0] waiting_count;
        logic [6:0] shared_holders;
        logic [6:0] exclusive_holders;
    } res_item_t;

    // One queued ticket
    typedef struct packed {
        logic       shared;
        logic [5:0] id;
    } entry_t;

    // Queue control from the sequencer
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t data;
    } q_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAKE
    } state_t;

    function automatic logic [6:0] sat_inc(input logic [6:0] v);
        sat_inc = (v < HOLD_SAT) ? v + 7'd1 : HOLD_SAT;
    endfunction

    function automatic logic below_limit(input logic [6:0] excl, input logic [6:0] limit);
        below_limit = (limit == 7'd0) || (excl < limit);
    endfunction

endpackage

/* design/fairrw_cell.sv */
// ----------------------------------------------------------------------------
// fairrw_cell
// One slot of the wait queue: load a new ticket or take the neighbor's.
// ----------------------------------------------------------------------------
module fairrw_cell
    import fairrw_pkg::*;
(
    input  logic   clk,
    input  logic   load,
    input  entry_t load_data,
    input  logic   shift,
    input  entry_t upper,
    output entry_t data
);

    entry_t data_reg;
    entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (load)
        begin
            data_next = load_data;
        end
        else if (shift)
        begin
            data_next = upper;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* design/fairrw_queue.sv */
// ----------------------------------------------------------------------------
// fairrw_queue
// Wait queue as a row of cells, head in cell 0; pop shifts toward the head.
// ----------------------------------------------------------------------------
module fairrw_queue
    import fairrw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  q_ctrl_t          ctrl,
    output logic [CNT_W-1:0] count,
    output entry_t           head,
    output entry_t           second
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    entry_t           cells [QUEUE_DEPTH];

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            entry_t upper;
            if (i == QUEUE_DEPTH - 1)
            begin : g_end
                assign upper = cells[i];
            end
            else
            begin : g_mid
                assign upper = cells[i+1];
            end

            fairrw_cell u_cell (
                .clk       (clk),
                .load      (ctrl.push && (count_reg == CNT_W'(i))),
                .load_data (ctrl.data),
                .shift     (ctrl.pop),
                .upper     (upper),
                .data      (cells[i])
            );
        end

        if (QUEUE_DEPTH > 1)
        begin : g_second
            assign second = cells[1];
        end
        else
        begin : g_single
            assign second = cells[0];
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;
    assign head  = cells[0];

endmodule

/* design/fair_reader_writer_gate.sv */
// ----------------------------------------------------------------------------
// fair_reader_writer_gate
// Fair shared/exclusive gate with an in-order wait queue of ticket cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_item): one item per request,
//   enter shared, enter exclusive or exit, tagged with a requester id.
//   Result channel (res_valid / res_stall / res_item): every request gives
//   one result; an exit may also give one woken result per released waiter.
//   The last result of a request carries last = 1. An unknown operation is
//   dropped without a result.
//   cfg_we / cfg_wdata write the exclusive-holder limit (0 = no limit);
//   write it only while no request is in flight.
// Timing: the request is registered, and its first result is formed in the
//   EXEC state and loaded into the output register; each woken waiter adds
//   a WAKE step, the wake sequencer popping one queue cell per cycle while
//   the receiver does not stall, through the single output register.
// Reset clears all counts and the queue fill, limit returns to 1.
// A stalled receiver holds the result register; the sequencer waits and
// req_stall stays high until the request's last result is loaded into it.
// ----------------------------------------------------------------------------
module fair_reader_writer_gate
    import fairrw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req_item,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item,
    input  logic      cfg_we,
    input  logic [6:0] cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] op_reg;
    logic [5:0] id_reg;
    logic       mode_reg;       // wake run is shared
    logic       mode_next;
    logic [6:0] sh_reg;
    logic [6:0] sh_next;
    logic [6:0] ex_reg;
    logic [6:0] ex_next;
    logic [6:0] max_excl_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    res_item_t  out_item_reg;
    res_item_t  out_item_next;

    q_ctrl_t          q_ctrl;
    logic [CNT_W-1:0] q_count;
    logic [CNT_W-1:0] cnt_after;
    logic [CNT_W+4:0] cnt_wide;
    entry_t           q_head;
    entry_t           q_second;

    logic out_free;
    logic load;
    logic more;         // another wake result follows
    logic accept;

    fairrw_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (q_ctrl),
        .count  (q_count),
        .head   (q_head),
        .second (q_second)
    );

    assign out_free  = !out_valid_reg || !res_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign cnt_wide  = {5'b0, cnt_after};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_item.operation inside
                               {OP_ENTER_SHARED, OP_ENTER_EXCL, OP_EXIT}))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = more ? S_WAKE : S_IDLE;
                end
            end
            S_WAKE:
            begin
                if (out_free && !more)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and result formation
    always_comb
    begin
        logic shared;
        logic go;
        sh_next    = sh_reg;
        ex_next    = ex_reg;
        mode_next  = mode_reg;
        load       = 1'b0;
        more       = 1'b0;
        cnt_after  = q_count;
        q_ctrl     = '{push: 1'b0, pop: 1'b0, data: '{shared: 1'b0, id: id_reg}};
        shared     = (op_reg == OP_ENTER_SHARED);
        go         = 1'b0;
        out_item_next = out_item_reg;
        out_item_next.requester_id_res = id_reg;
        out_item_next.kind        = KIND_GRANTED;
        out_item_next.shared_mode = 1'b0;
        out_item_next.last        = 1'b1;

        case (state_reg)
            S_EXEC:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (op_reg == OP_EXIT)
                    begin
                        if (ex_reg != 7'd0)
                        begin
                            ex_next = ex_reg - 7'd1;
                            out_item_next.kind = KIND_RELEASED;
                        end
                        else if (sh_reg != 7'd0)
                        begin
                            sh_next = sh_reg - 7'd1;
                            out_item_next.kind        = KIND_RELEASED;
                            out_item_next.shared_mode = 1'b1;
                        end
                        else
                        begin
                            out_item_next.kind = KIND_EXIT_ERR;
                        end
                        if (out_item_next.kind == KIND_RELEASED)
                        begin
                            // Check whether the head can be woken now
                            mode_next = q_head.shared;
                            if (q_count != '0)
                            begin
                                more = q_head.shared ? (ex_next == 7'd0)
                                     : ((sh_next == 7'd0) &&
                                        below_limit(ex_next, max_excl_reg));
                            end
                        end
                    end
                    else
                    begin
                        out_item_next.shared_mode = shared;
                        if (shared)
                        begin
                            go = (ex_reg == 7'd0) && (q_count == '0);
                        end
                        else
                        begin
                            go = (sh_reg == 7'd0) && (q_count == '0) &&
                                 below_limit(ex_reg, max_excl_reg);
                        end
                        if (go)
                        begin
                            if (shared)
                            begin
                                sh_next = sat_inc(sh_reg);
                            end
                            else
                            begin
                                ex_next = sat_inc(ex_reg);
                            end
                        end
                        else if (q_count >= CNT_W'(QUEUE_DEPTH))
                        begin
                            out_item_next.kind = KIND_FULL;
                        end
                        else
                        begin
                            out_item_next.kind = KIND_QUEUED;
                            q_ctrl.push        = 1'b1;
                            q_ctrl.data.shared = shared;
                            cnt_after          = q_count + CNT_W'(1);
                        end
                    end
                    out_item_next.last = !more;
                end
            end
            S_WAKE:
            begin
                if (out_free)
                begin
                    // Pop the head and hand it the access
                    load       = 1'b1;
                    q_ctrl.pop = 1'b1;
                    cnt_after  = q_count - CNT_W'(1);
                    if (mode_reg)
                    begin
                        sh_next = sat_inc(sh_reg);
                    end
                    else
                    begin
                        ex_next = sat_inc(ex_reg);
                    end
                    more = (cnt_after != '0) && (q_second.shared == mode_reg) &&
                           (mode_reg ? (ex_next == 7'd0)
                                     : ((sh_next == 7'd0) &&
                                        below_limit(ex_next, max_excl_reg)));
                    out_item_next.kind             = KIND_WOKEN;
                    out_item_next.requester_id_res = q_head.id;
                    out_item_next.shared_mode      = mode_reg;
                    out_item_next.last             = !more;
                end
            end
            default:
            begin
            end
        endcase

        out_item_next.waiting_count     = cnt_wide[4:0];
        out_item_next.shared_holders    = sh_next;
        out_item_next.exclusive_holders = ex_next;
        out_valid_next = load ? 1'b1 : (out_valid_reg && res_stall);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sh_reg        <= '0;
            ex_reg        <= '0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            max_excl_reg  <= MAX_EXCL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            sh_reg        <= sh_next;
            ex_reg        <= ex_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                max_excl_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers: capture the request, hold the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req_item.operation;
            id_reg <= req_item.requester_id;
        end
        if (load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

    // Shared and exclusive holders never coexist
    assert property (@(posedge clk) disable iff (!rst_n)
        !((sh_reg != 7'd0) && (ex_reg != 7'd0)))
        else $error("shared and exclusive holders at the same time");

    // The queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("wait queue over its depth");

    // Waking only happens with tickets in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAKE) |-> (q_count != '0))
        else $error("wake step with an empty queue");

endmodule

/* sim/fair_reader_writer_gate_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fair_reader_writer_gate_tb
// Self-checking bench for the fair shared/exclusive gate. A queue-based
// driver feeds request items and a clocked monitor checks every result item
// against an in-bench model of the holder counts and the ticket queue.
// Several exclusive limits are visited, including no limit, the holder
// saturation point itself and a value above it.
// ----------------------------------------------------------------------------
module fair_reader_writer_gate_tb;
    import fairrw_pkg::*;

    localparam int GATE_DEPTH  = 16;
    localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either channel
    localparam int SETTLE      = 12;     // quiet cycles before a limit write or the end

    // Operation code 3 is not defined by the gate: it must be dropped silently
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    req_item_t  req_item  = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_item_t  res_item;
    logic       cfg_we    = 1'b0;
    logic [6:0] cfg_wdata = '0;

    fair_reader_writer_gate #(
        .QUEUE_DEPTH(GATE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Gate model: holder counts, ticket ring and the limit, at block widths
    // ------------------------------------------------------------------------
    entry_t     tickets [0:GATE_DEPTH-1];
    int         q_head     = 0;
    int         q_tail     = 0;
    logic [4:0] wait_count = '0;
    logic [6:0] shr_cnt    = '0;
    logic [6:0] exc_cnt    = '0;
    logic [6:0] excl_limit = MAX_EXCL_RESET;

    res_item_t  pending_results [$];   // results the gate still owes, oldest first
    req_item_t  pending_reqs [$];      // request items not yet put on the channel

    // Bench bookkeeping
    int  mismatch_count = 0;
    int  requests_taken = 0;
    int  results_seen   = 0;
    int  full_hits      = 0;
    int  exit_err_hits  = 0;
    int  longest_wake   = 0;
    int  limits_used    = 1;
    bit  calm           = 1'b0;        // set for the final stretch: no gaps, no stalls
    bit  req_taken      = 1'b0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    int  quiet_cycles   = 0;

    function automatic logic [6:0] bump(input logic [6:0] v);
        bump = (v == HOLD_SAT) ? v : v + 7'd1;
    endfunction

    function automatic logic excl_room();
        excl_room = (excl_limit == 7'd0) || (exc_cnt < excl_limit);
    endfunction

    // Append one result carrying the counts as they stand now
    task automatic note(input logic [2:0] kind, input logic [5:0] id, input logic sh);
        res_item_t r;
        r.kind              = kind;
        r.requester_id_res  = id;
        r.shared_mode       = sh;
        r.last              = 1'b0;
        r.waiting_count     = wait_count;
        r.shared_holders    = shr_cnt;
        r.exclusive_holders = exc_cnt;
        pending_results.push_back(r);
    endtask

    // Work out every result one accepted request causes
    task automatic gate_predict(input req_item_t it);
        int        first_new;
        int        woken;
        logic      is_sh;
        logic      go;
        logic      released;
        entry_t    e;
        res_item_t r;
        first_new = pending_results.size();
        woken     = 0;
        released  = 1'b0;
        if (it.operation == OP_ENTER_SHARED || it.operation == OP_ENTER_EXCL)
        begin
            is_sh = (it.operation == OP_ENTER_SHARED);
            // Grant at once only when nobody waits: that keeps the queue fair
            if (is_sh)
                go = (exc_cnt == 7'd0) && (wait_count == 5'd0);
            else
                go = (shr_cnt == 7'd0) && (wait_count == 5'd0) && excl_room();
            if (go)
            begin
                if (is_sh)
                    shr_cnt = bump(shr_cnt);
                else
                    exc_cnt = bump(exc_cnt);
                note(KIND_GRANTED, it.requester_id, is_sh);
            end
            else if (wait_count >= GATE_DEPTH)
            begin
                note(KIND_FULL, it.requester_id, is_sh);
                full_hits++;
            end
            else
            begin
                e.shared        = is_sh;
                e.id            = it.requester_id;
                tickets[q_tail] = e;
                q_tail          = (q_tail + 1) % GATE_DEPTH;
                wait_count      = wait_count + 5'd1;
                note(KIND_QUEUED, it.requester_id, is_sh);
            end
        end
        else if (it.operation == OP_EXIT)
        begin
            // Release an exclusive hold first, then a shared one
            if (exc_cnt != 7'd0)
            begin
                exc_cnt  = exc_cnt - 7'd1;
                released = 1'b1;
                note(KIND_RELEASED, it.requester_id, 1'b0);
            end
            else if (shr_cnt != 7'd0)
            begin
                shr_cnt  = shr_cnt - 7'd1;
                released = 1'b1;
                note(KIND_RELEASED, it.requester_id, 1'b1);
            end
            else
            begin
                note(KIND_EXIT_ERR, it.requester_id, 1'b0);
                exit_err_hits++;
            end
            // Wake from the head: a run of shared tickets, or exclusive ones up to the limit
            if (released && wait_count != 5'd0)
            begin
                if (tickets[q_head].shared)
                begin
                    while (exc_cnt == 7'd0 && wait_count != 5'd0 && tickets[q_head].shared)
                    begin
                        e          = tickets[q_head];
                        q_head     = (q_head + 1) % GATE_DEPTH;
                        wait_count = wait_count - 5'd1;
                        shr_cnt    = bump(shr_cnt);
                        note(KIND_WOKEN, e.id, 1'b1);
                        woken++;
                    end
                end
                else
                begin
                    while (shr_cnt == 7'd0 && wait_count != 5'd0 && !tickets[q_head].shared
                           && excl_room())
                    begin
                        e          = tickets[q_head];
                        q_head     = (q_head + 1) % GATE_DEPTH;
                        wait_count = wait_count - 5'd1;
                        exc_cnt    = bump(exc_cnt);
                        note(KIND_WOKEN, e.id, 1'b0);
                        woken++;
                    end
                end
            end
            if (woken > longest_wake)
                longest_wake = woken;
        end
        // Mark the final result of this request
        if (pending_results.size() > first_new)
        begin
            r      = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    function automatic string res_text(input res_item_t r);
        res_text = $sformatf("kind=%0d id=%0d shared=%0d last=%0d waiting=%0d sh=%0d ex=%0d",
                             r.kind, r.requester_id_res, r.shared_mode, r.last,
                             r.waiting_count, r.shared_holders, r.exclusive_holders);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    task automatic check_result(input res_item_t got);
        res_item_t want;
        if (pending_results.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected result: %s", res_text(got)));
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.requester_id_res !== want.requester_id_res ||
                got.shared_mode !== want.shared_mode || got.last !== want.last ||
                got.waiting_count !== want.waiting_count ||
                got.shared_holders !== want.shared_holders ||
                got.exclusive_holders !== want.exclusive_holders)
                flag_mismatch($sformatf("result mismatch: expected %s, got %s",
                                        res_text(want), res_text(got)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : gate_monitor
        if (rst_n)
        begin
            req_taken = req_valid && !req_stall;
            // Check before predicting: a result never belongs to a request taken this edge
            if (res_valid && !res_stall)
            begin
                check_result(res_item);
                results_seen++;
            end
            if (req_taken)
            begin
                gate_predict(req_item);
                requests_taken++;
            end
            if (req_taken || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: advance at the falling edge, hold a stalled item
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : req_driver
        logic      next_valid;
        req_item_t next_item;
        next_valid = req_valid;
        next_item  = req_item;
        if (!rst_n)
        begin
            next_valid = 1'b0;
        end
        else if (!(req_valid && !req_taken))
        begin
            // Previous item went through (or none was up): pick the next one or idle
            next_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_reqs.size() != 0)
            begin
                if (!calm && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(0, 6);   // idle gap before the next item
                else
                begin
                    next_item  = pending_reqs.pop_front();
                    next_valid = 1'b1;
                end
            end
        end
        req_valid <= next_valid;
        req_item  <= next_item;
    end

    // ------------------------------------------------------------------------
    // Result receiver: stall in random bursts
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : res_receiver
        if (!rst_n || calm)
            res_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_req(input logic [1:0] op, input logic [5:0] id);
        req_item_t r;
        r.operation    = op;
        r.requester_id = id;
        pending_reqs.push_back(r);
    endtask

    // Random mix: w_sh / w_ex percent enters, 4 percent unknown codes, the rest exits
    task automatic queue_mix(input int n, input int w_sh, input int w_ex);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                queue_req(OP_UNUSED, 6'($urandom_range(0, 63)));
            else if (pick < 4 + w_sh)
                queue_req(OP_ENTER_SHARED, 6'($urandom_range(0, 63)));
            else if (pick < 4 + w_sh + w_ex)
                queue_req(OP_ENTER_EXCL, 6'($urandom_range(0, 63)));
            else
                queue_req(OP_EXIT, 6'($urandom_range(0, 63)));
        end
    endtask

    // Wait until every item is through and every result is in, then let the gate settle
    task automatic drain();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_reqs.size() != 0 || req_valid || pending_results.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Empty the gate from a known idle state: one exit per holder and waiter, plus one
    task automatic release_all();
        int n;
        n = int'(shr_cnt) + int'(exc_cnt) + int'(wait_count) + 1;
        for (int i = 0; i < n; i++)
            queue_req(OP_EXIT, 6'($urandom_range(0, 63)));
        drain();
    endtask

    task automatic write_limit(input logic [6:0] value);
        @(negedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        excl_limit  = value;
        @(negedge clk);
        cfg_we     <= 1'b0;
        limits_used++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, limit at its reset value of 1
        queue_req(OP_EXIT, 6'd63);             // exit with nothing held
        queue_req(OP_ENTER_SHARED, 6'd0);      // granted
        queue_req(OP_ENTER_EXCL, 6'd63);       // waits behind the shared holder
        queue_req(OP_ENTER_SHARED, 6'd1);      // waits behind the exclusive ticket
        queue_req(OP_UNUSED, 6'd21);           // dropped, no result
        queue_req(OP_EXIT, 6'd0);              // wakes the exclusive head only
        queue_req(OP_EXIT, 6'd63);             // wakes the shared ticket
        queue_req(OP_EXIT, 6'd1);
        // Fill the ring to the brim, overflow it, then wake the whole shared run
        queue_req(OP_ENTER_EXCL, 6'd5);
        for (int i = 0; i < GATE_DEPTH; i++)
            queue_req(OP_ENTER_SHARED, 6'($urandom_range(0, 63)));
        queue_req(OP_ENTER_SHARED, 6'd42);     // queue full
        queue_req(OP_EXIT, 6'd5);              // longest result burst
        drain();
        release_all();

        // No limit: saturate the exclusive count, leave some holders behind
        write_limit(7'd0);
        for (int i = 0; i < 66; i++)
            queue_req(OP_ENTER_EXCL, 6'($urandom_range(0, 63)));
        for (int i = 0; i < 3; i++)
            queue_req(OP_ENTER_SHARED, 6'($urandom_range(0, 63)));
        for (int i = 0; i < 2; i++)
            queue_req(OP_ENTER_EXCL, 6'($urandom_range(0, 63)));
        for (int i = 0; i < 60; i++)
            queue_req(OP_EXIT, 6'($urandom_range(0, 63)));
        queue_mix(20, 30, 40);
        drain();

        // Limit likely below the exclusive holders still present
        write_limit(7'd2);
        queue_mix(30, 30, 40);
        drain();
        release_all();

        // Limit at the saturation point: saturate the shared count
        write_limit(7'd64);
        for (int i = 0; i < 66; i++)
            queue_req(OP_ENTER_SHARED, 6'($urandom_range(0, 63)));
        queue_req(OP_ENTER_EXCL, 6'($urandom_range(0, 63)));
        queue_req(OP_ENTER_EXCL, 6'($urandom_range(0, 63)));
        queue_req(OP_ENTER_SHARED, 6'($urandom_range(0, 63)));
        for (int i = 0; i < 68; i++)
            queue_req(OP_EXIT, 6'($urandom_range(0, 63)));
        drain();

        // Largest limit, enter-heavy so the ring fills up
        write_limit(7'd127);
        queue_mix(30, 45, 35);
        drain();

        // More exits than in the other mixes, with a small limit
        write_limit(7'd3);
        queue_mix(30, 25, 25);
        drain();

        write_limit(7'd1);
        queue_mix(30, 35, 30);
        drain();

        // Final stretch at full rate with a random limit
        calm = 1'b1;
        write_limit(7'($urandom_range(0, 127)));
        queue_mix(50, 35, 30);
        drain();
        repeat (SETTLE) @(posedge clk);

        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    pending_results.size()));

        $display("Covered %0d requests and %0d results over %0d limit settings",
                 requests_taken, results_seen, limits_used);
        $display("Queue-full rejects %0d, exit errors %0d, longest wake run %0d, mismatches %0d",
                 full_hits, exit_err_hits, longest_wake, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
